### src/byte_range_set_tracker_top_assert.svh
// assertion macros for the range tracker
`ifndef BYTE_RANGE_SET_TRACKER_TOP_ASSERT_SVH
`define BYTE_RANGE_SET_TRACKER_TOP_ASSERT_SVH

// same-cycle implication
`define BRST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/brst_pkg.sv
`timescale 1ns / 1ps
package brst_pkg;

  localparam int MAX_RANGES_DEF  = 64;
  localparam int OFFSET_BITS_DEF = 48;
  localparam int FIELD_BITS      = 48;
  localparam int COUNT_BITS      = 7;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [FIELD_BITS-1:0] offset;
    logic [FIELD_BITS-1:0] length;
  } req_t;

  typedef struct packed {
    logic                  covered;
    logic [FIELD_BITS-1:0] granted_length;
    logic                  table_full;
    logic [COUNT_BITS-1:0] ranges_used;
  } rsp_t;

endpackage

### src/brst_mem.sv
`timescale 1ns / 1ps
module brst_mem import brst_pkg::*; #(
  parameter int DEPTH = MAX_RANGES_DEF,
  parameter int DW    = 2 * OFFSET_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/brst_ctrl.sv
`timescale 1ns / 1ps
module brst_ctrl import brst_pkg::*; #(
  parameter int MAX_RANGES  = MAX_RANGES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int IW = $clog2(MAX_RANGES),
  localparam int CW = $clog2(MAX_RANGES + 1),
  localparam int DW = 2 * OFFSET_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  req_t          req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rsp_t          rsp,
  output logic          mem_rd_en,
  output logic [IW-1:0] mem_rd_addr,
  input  logic [DW-1:0] mem_rd_data,
  output logic          mem_wr_en,
  output logic [IW-1:0] mem_wr_addr,
  output logic [DW-1:0] mem_wr_data
);

  localparam int OB = OFFSET_BITS;

  typedef enum logic [3:0] {
    IDLE, SCAN_RD, SCAN_CHK, DECIDE, ABS_RD, ABS_CHK, MV_SET, MV_RD, MV_WR, WR_NEW, RESP
  } state_t;

  state_t        state;
  logic          op;
  logic [OB-1:0] off, len, end_r;
  logic [OB-1:0] prev_s, prev_e, cur_s, cur_e, s_new, e_new;
  logic [CW-1:0] i, j, p, src, dst, n, count, count_next;
  logic          down;

  logic [OB-1:0] rs, re, off_in, len_in, avail, end_in;
  logic [OB:0]   sum;
  logic          hp, hc, hit_prev, hit_cur;

  assign rs     = mem_rd_data[DW-1:OB];
  assign re     = mem_rd_data[OB-1:0];
  assign off_in = OB'(req.offset);
  assign len_in = OB'(req.length);
  assign sum    = {1'b0, off_in} + {1'b0, len_in};
  assign end_in = sum[OB] ? {OB{1'b1}} : sum[OB-1:0];

  assign hp       = (i != '0);
  assign hc       = (i != count);
  assign hit_prev = hp && (off < prev_e);
  assign hit_cur  = hc && (cur_s == off);
  assign avail    = hit_prev ? (prev_e - off) : (cur_e - cur_s);

  assign req_ready = (state == IDLE);

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = i[IW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = dst[IW-1:0];
    mem_wr_data = mem_rd_data;
    case (state)
      SCAN_RD: begin
        mem_rd_en   = hc;
        mem_rd_addr = i[IW-1:0];
      end
      ABS_RD: begin
        mem_rd_en   = (j != count);
        mem_rd_addr = j[IW-1:0];
      end
      MV_RD: begin
        mem_rd_en   = (n != '0);
        mem_rd_addr = src[IW-1:0];
      end
      MV_WR: begin
        mem_wr_en = 1'b1;
      end
      WR_NEW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = p[IW-1:0];
        mem_wr_data = {s_new, e_new};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid) begin
            op    <= req.op;
            off   <= off_in;
            len   <= len_in;
            end_r <= end_in;
            i     <= '0;
            rsp   <= '0;
            state <= SCAN_RD;
          end
        end
        SCAN_RD: begin
          state <= hc ? SCAN_CHK : DECIDE;
        end
        SCAN_CHK: begin
          if (rs < off) begin
            prev_s <= rs;
            prev_e <= re;
            i      <= i + 1'b1;
            state  <= SCAN_RD;
          end else begin
            cur_s <= rs;
            cur_e <= re;
            state <= DECIDE;
          end
        end
        DECIDE: begin
          if (op == OP_FIND) begin
            if (hit_prev || hit_cur) begin
              rsp.covered        <= 1'b1;
              rsp.granted_length <= FIELD_BITS'((len < avail) ? len : avail);
            end
            state <= RESP;
          end else if (end_r > off) begin
            if (hp && (off <= prev_e)) begin
              if (end_r > prev_e) begin
                p     <= i - 1'b1;
                s_new <= prev_s;
                e_new <= end_r;
                j     <= i;
                state <= ABS_RD;
              end else begin
                state <= RESP;
              end
            end else if (hit_cur) begin
              if (end_r > cur_e) begin
                p     <= i;
                s_new <= off;
                e_new <= end_r;
                j     <= i + 1'b1;
                state <= ABS_RD;
              end else begin
                state <= RESP;
              end
            end else if (count >= CW'(MAX_RANGES)) begin
              rsp.table_full <= 1'b1;
              state          <= RESP;
            end else begin
              p     <= i;
              s_new <= off;
              e_new <= end_r;
              j     <= i;
              state <= ABS_RD;
            end
          end else begin
            state <= RESP;
          end
        end
        ABS_RD: begin
          state <= (j != count) ? ABS_CHK : MV_SET;
        end
        ABS_CHK: begin
          if (rs <= e_new) begin
            if (re > e_new) begin
              e_new <= re;
            end
            j     <= j + 1'b1;
            state <= ABS_RD;
          end else begin
            state <= MV_SET;
          end
        end
        MV_SET: begin
          count_next <= p + 1'b1 + (count - j);
          if (j > p + 1'b1) begin
            n    <= count - j;
            down <= 1'b1;
            src  <= j;
            dst  <= p + 1'b1;
          end else if (j < p + 1'b1) begin
            n    <= count - j;
            down <= 1'b0;
            src  <= count - 1'b1;
            dst  <= count;
          end else begin
            n <= '0;
          end
          state <= MV_RD;
        end
        MV_RD: begin
          state <= (n != '0) ? MV_WR : WR_NEW;
        end
        MV_WR: begin
          n     <= n - 1'b1;
          src   <= down ? src + 1'b1 : src - 1'b1;
          dst   <= down ? dst + 1'b1 : dst - 1'b1;
          state <= MV_RD;
        end
        WR_NEW: begin
          count <= count_next;
          state <= RESP;
        end
        RESP: begin
          if (!rsp_valid) begin
            rsp_valid       <= 1'b1;
            rsp.ranges_used <= COUNT_BITS'(count);
          end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### src/byte_range_set_tracker_top.sv
// find scans the stored ranges in order up to the first one not below the offset, then
// raises the response beat
// an add that inserts or extends a range goes through scan, merge, shift and write
// one beat at a time: the next request is taken once the response beat has left
// each work state issues at most one read or one write of the single range memory
// reset clears the range count and handshake state; memory contents are not cleared
`timescale 1ns / 1ps
`include "byte_range_set_tracker_top_assert.svh"
module byte_range_set_tracker_top import brst_pkg::*; #(
  parameter int MAX_RANGES  = MAX_RANGES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int IW = $clog2(MAX_RANGES);
  localparam int DW = 2 * OFFSET_BITS;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] rd_data, wr_data;

  brst_ctrl #(
    .MAX_RANGES (MAX_RANGES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .mem_rd_en  (rd_en),
    .mem_rd_addr(rd_addr),
    .mem_rd_data(rd_data),
    .mem_wr_en  (wr_en),
    .mem_wr_addr(wr_addr),
    .mem_wr_data(wr_data)
  );

  brst_mem #(
    .DEPTH(MAX_RANGES),
    .DW   (DW)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  `BRST_ASSERT_IMP(a_idle_accept, req_valid && req_ready, !rsp_valid, "accept while response pending")
  `BRST_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second beat taken early")
  `BRST_ASSERT_IMP(a_full_add_only, rsp_valid && rsp.table_full, !rsp.covered && rsp.ranges_used == COUNT_BITS'(MAX_RANGES), "table full flag inconsistent")
  `BRST_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp.covered, rsp.granted_length == '0, "length granted without cover")

endmodule
